[design/assert_macros.svh]
// Assertion macros for the port checker of the job schedule block.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[design/jss_pkg.sv]
// Package of the job schedule block: sizes, policy and register codes,
// the job record carried through the cell ring, and the sequencer states.
`default_nettype none

package jss_pkg;

    localparam int MAX_JOBS = 32;
    localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    localparam int ID_W   = 16;
    localparam int ARR_W  = 16;
    localparam int LEN_W  = 12;
    localparam int TICK_W = 18;
    localparam int SUM_W  = TICK_W + CNT_W;
    localparam int POL_W  = 3;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 128;
    localparam int PADDR_W  = 3;

    localparam logic [POL_W-1:0] POL_FIFO = 3'd0;
    localparam logic [POL_W-1:0] POL_SJF  = 3'd1;
    localparam logic [POL_W-1:0] POL_LJF  = 3'd2;
    localparam logic [POL_W-1:0] POL_SRTF = 3'd3;
    localparam logic [POL_W-1:0] POL_RR   = 3'd4;

    // Word index of the policy register (paddr bit 2).
    localparam logic REG_POLICY = 1'b0;

    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [ARR_W-1:0]  arrival;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  progress;
        logic [TICK_W-1:0] start;
        logic [TICK_W-1:0] finish;
        logic              done;
        logic              started;
    } job_t;

    typedef struct packed {
        logic load;
        logic rotate;
        logic clear;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_FIND,
        ST_DECIDE,
        ST_UPD,
        ST_DIV,
        ST_FINAL
    } state_t;

endpackage

`default_nettype wire

[design/job_schedule_simulator.sv]
// Job schedule planner. Jobs are loaded one per transaction into a
// ring of MAX_JOBS cells kept sorted by arrival; a transaction with tlast starts
// planning under the policy register and one result per stored job follows.
// All decisions are made at the head of the ring while the n stored jobs rotate
// past it, one per cycle unless a stalled result holds the update pass: each
// scheduling step is a search pass, a decision and an update pass. FIFO and
// shortest or longest first need n steps, shortest remaining first needs one
// step per tick of service, and round robin one step per round. The final
// result waits for the averaging divider. Jobs beyond MAX_JOBS are dropped and
// flagged in the results.
`default_nettype none

module job_schedule_simulator (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // s_tdata: job_ident[15:0], arrival[31:16], run_length[43:32], zero fill
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [jss_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                         s_tlast,
    // m_tdata: out_ident[15:0], start_tick[33:16], finish_tick[51:34],
    // turnaround[69:52], response[87:70], avg_turnaround[105:88],
    // avg_response[123:106], dropped[124], zero fill
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [jss_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tlast,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [jss_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import jss_pkg::*;

    state_t            state_reg,     state_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic              ovf_reg,       ovf_next;
    logic [POL_W-1:0]  policy_reg;
    logic [POL_W-1:0]  pol_reg,       pol_next;
    logic [TICK_W-1:0] clock_reg,     clock_next;
    logic [TICK_W-1:0] round_clk_reg, round_clk_next;
    logic [IDX_W-1:0]  step_reg,      step_next;
    logic [IDX_W-1:0]  pick_reg,      pick_next;
    logic [CNT_W-1:0]  done_cnt_reg,  done_cnt_next;
    logic [SUM_W-1:0]  sum_t_reg,     sum_t_next;
    logic [SUM_W-1:0]  sum_r_reg,     sum_r_next;
    logic              any_rdy_reg,   any_rdy_next;
    logic [IDX_W-1:0]  pick_a_reg,    pick_a_next;
    logic [LEN_W-1:0]  key_a_reg,     key_a_next;
    logic              have_first_reg, have_first_next;
    logic [ARR_W-1:0]  first_arr_reg, first_arr_next;
    logic [IDX_W-1:0]  pick_b_reg,    pick_b_next;
    logic [LEN_W-1:0]  key_b_reg,     key_b_next;
    logic              m_valid_reg,   m_valid_next;

    logic [ID_W-1:0]   o_ident_reg,   o_ident_next;
    logic [TICK_W-1:0] o_start_reg,   o_start_next;
    logic [TICK_W-1:0] o_finish_reg,  o_finish_next;
    logic [TICK_W-1:0] o_turn_reg,    o_turn_next;
    logic [TICK_W-1:0] o_resp_reg,    o_resp_next;
    logic [TICK_W-1:0] o_avg_t_reg,   o_avg_t_next;
    logic [TICK_W-1:0] o_avg_r_reg,   o_avg_r_next;
    logic              o_drop_reg,    o_drop_next;
    logic              o_last_reg,    o_last_next;

    cell_cmd_t cmd;
    job_t      new_job;
    job_t      head;
    job_t      head_mod;
    job_t      head_upd;
    job_t      q   [MAX_JOBS];
    logic      gt  [MAX_JOBS];

    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  quo_a;
    logic [SUM_W-1:0]  quo_b;

    logic [IDX_W-1:0]  last_idx;
    logic              ticked;
    logic              sel_job;
    logic              exec_done;
    logic [TICK_W-1:0] exec_clock;
    logic [TICK_W-1:0] turn_val;
    logic [TICK_W-1:0] resp_val;
    logic [SUM_W-1:0]  sum_t_add;
    logic [SUM_W-1:0]  sum_r_add;
    logic              h_unf;
    logic              h_rdy;
    logic [LEN_W-1:0]  h_key;
    logic              stall;

    function automatic logic better(input logic [POL_W-1:0] pol,
                                    input logic [LEN_W-1:0] a,
                                    input logic [LEN_W-1:0] b);
        logic r;
        case (pol)
            POL_SJF:  r = (a < b);
            POL_LJF:  r = (a > b);
            POL_SRTF: r = (a < b);
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POLICY) ? {{(32 - POL_W){1'b0}}, policy_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_FIFO;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_POLICY)) begin
            policy_reg <= pwdata[POL_W-1:0];
        end
    end

    // Incoming job record; a run length of zero counts as one tick.
    always_comb begin
        new_job         = '0;
        new_job.ident   = s_tdata[15:0];
        new_job.arrival = s_tdata[31:16];
        new_job.length  = (s_tdata[43:32] == '0) ? LEN_W'(1) : s_tdata[43:32];
    end

    // The ring closes at the last stored job.
    for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
        job_t left_job;
        job_t right_job;
        logic left_gt;
        if (i == 0) begin : g_first
            assign left_job = '0;
            assign left_gt  = 1'b0;
        end else begin : g_mid
            assign left_job = q[i-1];
            assign left_gt  = gt[i-1];
        end
        if (i == MAX_JOBS - 1) begin : g_end
            assign right_job = head_mod;
        end else begin : g_inner
            assign right_job = (count_reg == CNT_W'(i + 1)) ? head_mod : q[i+1];
        end
        jss_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .new_job   (new_job),
            .left_job  (left_job),
            .right_job (right_job),
            .left_gt   (left_gt),
            .valid     (CNT_W'(i) < count_reg),
            .at_count  (CNT_W'(i) == count_reg),
            .job_q     (q[i]),
            .gt        (gt[i])
        );
    end

    assign head = q[0];

    jss_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_a   (sum_t_add),
        .num_b   (sum_r_add),
        .den     (count_reg),
        .done    (div_done),
        .quo_a   (quo_a),
        .quo_b   (quo_b)
    );

    assign last_idx = IDX_W'(count_reg - 1'b1);
    assign ticked   = (pol_reg == POL_SRTF) || (pol_reg == POL_RR);
    assign h_unf    = !head.done;
    assign h_rdy    = h_unf && (TICK_W'(head.arrival) <= clock_reg);
    assign h_key    = (pol_reg == POL_SRTF) ? (head.length - head.progress) : head.length;
    assign sel_job  = (pol_reg == POL_RR)
                    ? (h_unf && (TICK_W'(head.arrival) <= round_clk_reg))
                    : (step_reg == pick_reg);

    // Service given to the job at the head during an update pass.
    always_comb begin
        head_upd   = head;
        exec_done  = 1'b0;
        exec_clock = clock_reg;
        if (sel_job) begin
            if (!ticked) begin
                head_upd.start   = clock_reg;
                head_upd.started = 1'b1;
                exec_clock       = clock_reg + TICK_W'(head.length);
                head_upd.finish  = exec_clock;
                head_upd.done    = 1'b1;
                exec_done        = 1'b1;
            end else begin
                if (!head.started) begin
                    head_upd.start   = clock_reg;
                    head_upd.started = 1'b1;
                end
                head_upd.progress = head.progress + 1'b1;
                exec_clock        = clock_reg + 1'b1;
                if (head_upd.progress >= head.length) begin
                    head_upd.finish = exec_clock;
                    head_upd.done   = 1'b1;
                    exec_done       = 1'b1;
                end
            end
        end
    end

    assign turn_val  = head_upd.finish - TICK_W'(head.arrival);
    assign resp_val  = head_upd.start - TICK_W'(head.arrival);
    assign sum_t_add = sum_t_reg + SUM_W'(turn_val);
    assign sum_r_add = sum_r_reg + SUM_W'(resp_val);
    assign stall     = exec_done && m_valid_reg && !m_tready;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        pol_next        = pol_reg;
        clock_next      = clock_reg;
        round_clk_next  = round_clk_reg;
        step_next       = step_reg;
        pick_next       = pick_reg;
        done_cnt_next   = done_cnt_reg;
        sum_t_next      = sum_t_reg;
        sum_r_next      = sum_r_reg;
        any_rdy_next    = any_rdy_reg;
        pick_a_next     = pick_a_reg;
        key_a_next      = key_a_reg;
        have_first_next = have_first_reg;
        first_arr_next  = first_arr_reg;
        pick_b_next     = pick_b_reg;
        key_b_next      = key_b_reg;
        m_valid_next    = m_valid_reg;
        o_ident_next    = o_ident_reg;
        o_start_next    = o_start_reg;
        o_finish_next   = o_finish_reg;
        o_turn_next     = o_turn_reg;
        o_resp_next     = o_resp_reg;
        o_avg_t_next    = o_avg_t_reg;
        o_avg_r_next    = o_avg_r_reg;
        o_drop_next     = o_drop_reg;
        o_last_next     = o_last_reg;
        cmd             = '0;
        head_mod        = head;
        div_start       = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    if (count_reg < CNT_W'(MAX_JOBS)) begin
                        cmd.load   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        pol_next   = (policy_reg > POL_RR) ? POL_FIFO : policy_reg;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                cmd.clear       = 1'b1;
                clock_next      = TICK_W'(head.arrival);
                done_cnt_next   = '0;
                sum_t_next      = '0;
                sum_r_next      = '0;
                any_rdy_next    = 1'b0;
                have_first_next = 1'b0;
                step_next       = '0;
                state_next      = ST_FIND;
            end
            ST_FIND: begin
                // Track the best ready job, and the best job among those
                // arriving first in case the clock has to jump ahead.
                cmd.rotate = 1'b1;
                if (h_rdy && (!any_rdy_reg || better(pol_reg, h_key, key_a_reg))) begin
                    any_rdy_next = 1'b1;
                    pick_a_next  = step_reg;
                    key_a_next   = h_key;
                end
                if (h_unf && !have_first_reg) begin
                    have_first_next = 1'b1;
                    first_arr_next  = head.arrival;
                    pick_b_next     = step_reg;
                    key_b_next      = h_key;
                end else if (h_unf && (head.arrival == first_arr_reg)
                             && better(pol_reg, h_key, key_b_reg)) begin
                    pick_b_next = step_reg;
                    key_b_next  = h_key;
                end
                if (step_reg == last_idx) begin
                    step_next  = '0;
                    state_next = ST_DECIDE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DECIDE: begin
                if (any_rdy_reg) begin
                    pick_next      = pick_a_reg;
                    round_clk_next = clock_reg;
                end else begin
                    pick_next      = pick_b_reg;
                    clock_next     = TICK_W'(first_arr_reg);
                    round_clk_next = TICK_W'(first_arr_reg);
                end
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (!stall) begin
                    cmd.rotate = 1'b1;
                    head_mod   = head_upd;
                    clock_next = exec_clock;
                    if (exec_done) begin
                        done_cnt_next = done_cnt_reg + 1'b1;
                        sum_t_next    = sum_t_add;
                        sum_r_next    = sum_r_add;
                        o_ident_next  = head.ident;
                        o_start_next  = head_upd.start;
                        o_finish_next = head_upd.finish;
                        o_turn_next   = turn_val;
                        o_resp_next   = resp_val;
                        o_avg_t_next  = '0;
                        o_avg_r_next  = '0;
                        o_drop_next   = ovf_reg;
                        o_last_next   = 1'b0;
                    end
                    if (exec_done && (done_cnt_reg + 1'b1 == count_reg)) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        if (exec_done) begin
                            m_valid_next = 1'b1;
                        end
                        if (step_reg == last_idx) begin
                            step_next       = '0;
                            any_rdy_next    = 1'b0;
                            have_first_next = 1'b0;
                            state_next      = ST_FIND;
                        end else begin
                            step_next = step_reg + 1'b1;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    o_avg_t_next = quo_a[TICK_W-1:0];
                    o_avg_r_next = quo_b[TICK_W-1:0];
                    o_last_next  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (m_valid_reg && m_tready) begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pol_reg        <= POL_FIFO;
            clock_reg      <= '0;
            round_clk_reg  <= '0;
            step_reg       <= '0;
            pick_reg       <= '0;
            done_cnt_reg   <= '0;
            sum_t_reg      <= '0;
            sum_r_reg      <= '0;
            any_rdy_reg    <= 1'b0;
            have_first_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pol_reg        <= pol_next;
            clock_reg      <= clock_next;
            round_clk_reg  <= round_clk_next;
            step_reg       <= step_next;
            pick_reg       <= pick_next;
            done_cnt_reg   <= done_cnt_next;
            sum_t_reg      <= sum_t_next;
            sum_r_reg      <= sum_r_next;
            any_rdy_reg    <= any_rdy_next;
            have_first_reg <= have_first_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pick_a_reg    <= pick_a_next;
        key_a_reg     <= key_a_next;
        first_arr_reg <= first_arr_next;
        pick_b_reg    <= pick_b_next;
        key_b_reg     <= key_b_next;
        o_ident_reg   <= o_ident_next;
        o_start_reg   <= o_start_next;
        o_finish_reg  <= o_finish_next;
        o_turn_reg    <= o_turn_next;
        o_resp_reg    <= o_resp_next;
        o_avg_t_reg   <= o_avg_t_next;
        o_avg_r_reg   <= o_avg_r_next;
        o_drop_reg    <= o_drop_next;
        o_last_reg    <= o_last_next;
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {3'b000, o_drop_reg, o_avg_r_reg, o_avg_t_reg, o_resp_reg,
                       o_turn_reg, o_finish_reg, o_start_reg, o_ident_reg};

endmodule

`default_nettype wire

[design/jss_cell.sv]
// One cell of the job ring: holds one job record, takes part in the sorted
// insertion while loading and passes its record to its neighbor when rotating.
// Depends on jss_pkg.
`default_nettype none

module jss_cell (
    input  wire logic               aclk,
    input  wire jss_pkg::cell_cmd_t cmd,
    input  wire jss_pkg::job_t      new_job,
    input  wire jss_pkg::job_t      left_job,
    input  wire jss_pkg::job_t      right_job,
    input  wire logic               left_gt,
    input  wire logic               valid,
    input  wire logic               at_count,
    output jss_pkg::job_t           job_q,
    output logic                    gt
);
    import jss_pkg::*;

    job_t job_reg;
    job_t job_next;

    // Stored jobs later than the new one move one place up, so equal
    // arrivals keep their loading order.
    assign gt    = valid && (job_reg.arrival > new_job.arrival);
    assign job_q = job_reg;

    always_comb begin
        job_next = job_reg;
        if (cmd.load) begin
            if (left_gt) begin
                job_next = left_job;
            end else if (gt || at_count) begin
                job_next = new_job;
            end
        end else if (cmd.rotate) begin
            job_next = right_job;
        end
        if (cmd.clear) begin
            job_next.done     = 1'b0;
            job_next.started  = 1'b0;
            job_next.progress = '0;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

endmodule

`default_nettype wire

[design/jss_div.sv]
// Restoring divider for the two schedule averages: one quotient bit of each
// sum per cycle against the shared job count. Depends on jss_pkg.
`default_nettype none

module jss_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [jss_pkg::SUM_W-1:0] num_a,
    input  wire logic [jss_pkg::SUM_W-1:0] num_b,
    input  wire logic [jss_pkg::CNT_W-1:0] den,
    output logic                           done,
    output logic [jss_pkg::SUM_W-1:0]      quo_a,
    output logic [jss_pkg::SUM_W-1:0]      quo_b
);
    import jss_pkg::*;

    localparam int ITER_W = $clog2(SUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [SUM_W-1:0]  na_reg;
    logic [SUM_W-1:0]  nb_reg;
    logic [CNT_W:0]    ra_reg;
    logic [CNT_W:0]    rb_reg;
    logic [CNT_W-1:0]  den_reg;

    logic [CNT_W:0] sh_a;
    logic [CNT_W:0] sh_b;
    logic           qa;
    logic           qb;
    logic [CNT_W:0] ra_next;
    logic [CNT_W:0] rb_next;

    always_comb begin
        sh_a    = {ra_reg[CNT_W-1:0], na_reg[SUM_W-1]};
        sh_b    = {rb_reg[CNT_W-1:0], nb_reg[SUM_W-1]};
        qa      = (sh_a >= {1'b0, den_reg});
        qb      = (sh_b >= {1'b0, den_reg});
        ra_next = qa ? (sh_a - {1'b0, den_reg}) : sh_a;
        rb_next = qb ? (sh_b - {1'b0, den_reg}) : sh_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end else if (busy_reg) begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == ITER_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The dividend registers fill up with quotient bits from the bottom.
    always_ff @(posedge aclk) begin
        if (start) begin
            na_reg  <= num_a;
            nb_reg  <= num_b;
            ra_reg  <= '0;
            rb_reg  <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            na_reg <= {na_reg[SUM_W-2:0], qa};
            nb_reg <= {nb_reg[SUM_W-2:0], qb};
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
    end

    assign done  = done_reg;
    assign quo_a = na_reg;
    assign quo_b = nb_reg;

endmodule

`default_nettype wire

[design/jss_port_check.sv]
// Port-level checks of the job schedule block, attached by a bind below.
// Depends on jss_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module jss_port_check (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         s_tlast,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [jss_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                         m_tlast
);
    import jss_pkg::*;

    `JSS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result withdrawn while stalled")
    `JSS_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    `JSS_ASSERT_SAME(a_no_overlap, aclk, aresetn, s_tready, !m_tvalid, "loading while a result is pending")
    `JSS_ASSERT_NEXT(a_plan_starts, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready, "still loading after the last job")
    `JSS_ASSERT_SAME(a_avg_zero, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[123:88] == '0, "averages on a non-final result")

endmodule

bind job_schedule_simulator jss_port_check u_port_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[dv/tb_job_schedule_simulator.sv]
// Testbench of the job schedule planner: it loads job sets over the input
// stream, plans each set in its own copy of the scheduler and compares every
// result transaction. Depends on jss_pkg and job_schedule_simulator only.
`default_nettype none

module tb_job_schedule_simulator;
    timeunit 1ns;
    timeprecision 1ps;

    import jss_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE      = 80;

    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [TICK_W-1:0] start;
        logic [TICK_W-1:0] finish;
        logic [TICK_W-1:0] turn;
        logic [TICK_W-1:0] resp;
        logic [TICK_W-1:0] avg_turn;
        logic [TICK_W-1:0] avg_resp;
        logic              dropped;
        logic              last;
    } sched_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // s_tdata: job_ident[15:0], arrival[31:16], run_length[43:32], zero fill
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // m_tdata: out_ident[15:0], start_tick[33:16], finish_tick[51:34],
    // turnaround[69:52], response[87:70], avg_turnaround[105:88],
    // avg_response[123:106], dropped[124], zero fill
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Scheduler copy kept by the testbench.
    logic [POL_W-1:0]  cur_policy;
    int unsigned       tab_ident[MAX_JOBS];
    int unsigned       tab_arr[MAX_JOBS];
    int unsigned       tab_len[MAX_JOBS];
    int unsigned       tab_start[MAX_JOBS];
    int unsigned       tab_finish[MAX_JOBS];
    int unsigned       tab_prog[MAX_JOBS];
    bit                tab_done[MAX_JOBS];
    bit                tab_started[MAX_JOBS];
    int unsigned       finish_order[MAX_JOBS];
    int unsigned       stored_jobs;
    bit                overflowed;
    int unsigned       sim_tick;

    sched_result_t     sched_q[$];
    int                errors = 0;
    int                cycles = 0;
    int                jobs_sent = 0;
    bit                no_idle = 1'b0;
    bit                hold_req = 1'b0;
    bit                hold_req_d = 1'b0;
    int                hold_left = 0;

    job_schedule_simulator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, sched_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        hold_req_d <= hold_req;
        if (hold_req && !hold_req_d) begin
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 17);
        end
    end

    // Move the clock to the earliest unfinished arrival when nothing is ready.
    function automatic void skip_idle();
        for (int unsigned i = 0; i < stored_jobs; i++)
            if (!tab_done[i] && tab_arr[i] <= sim_tick)
                return;
        for (int unsigned i = 0; i < stored_jobs; i++)
            if (!tab_done[i]) begin
                sim_tick = tab_arr[i];
                return;
            end
    endfunction

    function automatic bit serve_tick(int unsigned j);
        if (!tab_started[j]) begin
            tab_started[j] = 1'b1;
            tab_start[j] = sim_tick;
        end
        tab_prog[j]++;
        sim_tick++;
        if (tab_prog[j] >= tab_len[j]) begin
            tab_done[j] = 1'b1;
            tab_finish[j] = sim_tick;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Plans the stored set and queues one result per job in emission order.
    function automatic void plan_jobs();
        logic [POL_W-1:0] pol;
        int               pick;
        int unsigned      n_done;
        bit               snap[MAX_JOBS];
        bit               any;
        longint unsigned  sum_t;
        longint unsigned  sum_r;
        sched_result_t    r;
        int unsigned      j;
        pol = (cur_policy <= POL_RR) ? cur_policy : POL_FIFO;
        n_done = 0;
        sum_t = 0;
        sum_r = 0;
        for (int i = 0; i < MAX_JOBS; i++) begin
            tab_done[i] = 1'b0;
            tab_started[i] = 1'b0;
            tab_prog[i] = 0;
        end
        sim_tick = tab_arr[0];
        if (pol == POL_FIFO || pol == POL_SJF || pol == POL_LJF) begin
            for (int unsigned k = 0; k < stored_jobs; k++) begin
                pick = -1;
                skip_idle();
                for (int unsigned i = 0; i < stored_jobs; i++) begin
                    if (tab_done[i] || tab_arr[i] > sim_tick)
                        continue;
                    if (pick < 0 || (pol == POL_SJF && tab_len[i] < tab_len[pick]) ||
                        (pol == POL_LJF && tab_len[i] > tab_len[pick]))
                        pick = i;
                    if (pol == POL_FIFO)
                        break;
                end
                if (pick < 0)
                    break;
                tab_done[pick] = 1'b1;
                tab_start[pick] = sim_tick;
                sim_tick += tab_len[pick];
                tab_finish[pick] = sim_tick;
                finish_order[k] = pick;
            end
        end else if (pol == POL_SRTF) begin
            while (n_done < stored_jobs) begin
                pick = -1;
                skip_idle();
                for (int unsigned i = 0; i < stored_jobs; i++) begin
                    if (tab_done[i] || tab_arr[i] > sim_tick)
                        continue;
                    if (pick < 0 || tab_len[i] - tab_prog[i] < tab_len[pick] - tab_prog[pick])
                        pick = i;
                end
                if (pick < 0)
                    break;
                if (serve_tick(pick))
                    finish_order[n_done++] = pick;
            end
        end else begin
            while (n_done < stored_jobs) begin
                any = 1'b0;
                skip_idle();
                for (int unsigned i = 0; i < stored_jobs; i++) begin
                    snap[i] = !tab_done[i] && tab_arr[i] <= sim_tick;
                    any |= snap[i];
                end
                if (!any)
                    break;
                for (int unsigned i = 0; i < stored_jobs; i++)
                    if (snap[i] && serve_tick(i))
                        finish_order[n_done++] = i;
            end
        end
        for (int unsigned k = 0; k < stored_jobs; k++) begin
            j = finish_order[k];
            r.ident    = ID_W'(tab_ident[j]);
            r.start    = TICK_W'(tab_start[j]);
            r.finish   = TICK_W'(tab_finish[j]);
            r.turn     = TICK_W'(tab_finish[j] - tab_arr[j]);
            r.resp     = TICK_W'(tab_start[j] - tab_arr[j]);
            sum_t     += 64'(tab_finish[j] - tab_arr[j]);
            sum_r     += 64'(tab_start[j] - tab_arr[j]);
            r.dropped  = overflowed;
            r.last     = (k == stored_jobs - 1);
            r.avg_turn = r.last ? TICK_W'(sum_t / stored_jobs) : '0;
            r.avg_resp = r.last ? TICK_W'(sum_r / stored_jobs) : '0;
            sched_q.push_back(r);
        end
        stored_jobs = 0;
        overflowed = 1'b0;
    endfunction

    // Stable insertion by arrival; a marked job triggers planning.
    function automatic void store_job(int unsigned id, int unsigned arr, int unsigned len,
                                      bit last);
        int unsigned pos;
        if (len == 0)
            len = 1;
        if (stored_jobs < MAX_JOBS) begin
            pos = stored_jobs;
            while (pos > 0 && tab_arr[pos-1] > arr) begin
                tab_ident[pos] = tab_ident[pos-1];
                tab_arr[pos]   = tab_arr[pos-1];
                tab_len[pos]   = tab_len[pos-1];
                pos--;
            end
            tab_ident[pos] = id;
            tab_arr[pos]   = arr;
            tab_len[pos]   = len;
            stored_jobs++;
        end else begin
            overflowed = 1'b1;
        end
        if (last)
            plan_jobs();
    endfunction

    always @(posedge aclk) begin
        sched_result_t want;
        sched_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.ident    = m_tdata[15:0];
            got.start    = m_tdata[33:16];
            got.finish   = m_tdata[51:34];
            got.turn     = m_tdata[69:52];
            got.resp     = m_tdata[87:70];
            got.avg_turn = m_tdata[105:88];
            got.avg_resp = m_tdata[123:106];
            got.dropped  = m_tdata[124];
            got.last     = m_tlast;
            if (sched_q.size() == 0) begin
                $display("%0t unexpected result: expected none, actual ident %h", $time,
                         got.ident);
                errors++;
            end else begin
                want = sched_q.pop_front();
                if (got != want) begin
                    $display(
                        "%0t expected: id %h st %0d fin %0d ta %0d rs %0d av %0d/%0d dr %b lt %b",
                        $time, want.ident, want.start, want.finish, want.turn, want.resp,
                        want.avg_turn, want.avg_resp, want.dropped, want.last);
                    $display(
                        "%0t actual:   id %h st %0d fin %0d ta %0d rs %0d av %0d/%0d dr %b lt %b",
                        $time, got.ident, got.start, got.finish, got.turn, got.resp,
                        got.avg_turn, got.avg_resp, got.dropped, got.last);
                    errors++;
                end
            end
        end
    end

    // Offers one job; valid stays high afterward so back-to-back jobs need no gap.
    task automatic send_job(int unsigned id, int unsigned arr, int unsigned len, bit last);
        while (!no_idle && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, len[LEN_W-1:0], arr[ARR_W-1:0], id[ID_W-1:0]};
        s_tlast  <= last;
        do
            @(posedge aclk);
        while (!s_tready);
        jobs_sent++;
        store_job(id, arr, len, last);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sched_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_policy(logic [POL_W-1:0] pol);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_POLICY, 2'b00};
        pwdata  <= 32'(pol);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_policy = pol;
    endtask

    // Field extremes and a zero length under the reset policy.
    task automatic test_extremes();
        send_job(16'h0000, 0, 1, 1'b0);
        send_job(16'hFFFF, 16'hFFFF, 12'hFFF, 1'b0);
        send_job(16'h5A5A, 0, 0, 1'b1);
        wait_drained();
    endtask

    // Out-of-order arrivals, equal arrivals and an idle gap under each code but 6.
    task automatic test_policies();
        logic [POL_W-1:0] pol;
        for (int p = 0; p < 8; p++) begin
            pol = POL_W'(p);
            if (p == 6)
                continue;
            write_policy(pol);
            send_job(16'h00A1, 50, 6, 1'b0);
            send_job(16'h00B2, 10, 6, 1'b0);
            send_job(16'h00C3, 10, 2, 1'b0);
            send_job(16'h00D4, 300, 1, 1'b1);
            wait_drained();
        end
    endtask

    // More jobs than the table holds; the mark rides on an ignored job.
    task automatic test_overflow();
        write_policy(POL_SJF);
        for (int i = 0; i < MAX_JOBS + 2; i++)
            send_job($urandom_range(16'hFFFF), $urandom_range(200), $urandom_range(1, 9),
                     i == MAX_JOBS + 1);
        wait_drained();
        write_policy(POL_RR);
        for (int i = 0; i < MAX_JOBS + 1; i++)
            send_job(i, $urandom_range(40), $urandom_range(1, 6), i == MAX_JOBS);
        wait_drained();
    endtask

    // Long receiver hold-off while two sets are offered back to back.
    task automatic test_backpressure();
        write_policy(POL_SRTF);
        hold_req <= 1'b1;
        for (int s = 0; s < 2; s++)
            for (int i = 0; i < 8; i++)
                send_job($urandom_range(16'hFFFF), $urandom_range(60), $urandom_range(1, 12),
                         i == 7);
        hold_req <= 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        int unsigned set_size;
        int unsigned base;
        int unsigned spread;
        int unsigned len;
        int          start_count;
        logic [POL_W-1:0] pol;
        start_count = jobs_sent;
        while (jobs_sent - start_count < 96) begin
            pol = POL_W'($urandom_range(7));
            write_policy(pol);
            // The first stretch of sets runs with neither side idling.
            no_idle = (jobs_sent - start_count < 30);
            set_size = ($urandom_range(9) == 0) ? $urandom_range(9, MAX_JOBS)
                                                : $urandom_range(1, 8);
            base   = $urandom_range(16'hFFFF);
            spread = ($urandom_range(3) == 0) ? 16'hFFFF : $urandom_range(1, 80);
            for (int unsigned i = 0; i < set_size; i++) begin
                // Full-range lengths only where the planner stays quick.
                if ((pol <= POL_LJF || pol > POL_RR || set_size <= 2) &&
                    $urandom_range(9) == 0)
                    len = $urandom_range(12'hFFF);
                else
                    len = $urandom_range(15);
                send_job($urandom_range(16'hFFFF),
                         (spread == 16'hFFFF) ? $urandom_range(16'hFFFF)
                                              : (base + $urandom_range(spread)) & 16'hFFFF,
                         len, i == set_size - 1);
            end
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        cur_policy  = POL_FIFO;
        stored_jobs = 0;
        overflowed  = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE) @(posedge aclk);
        test_extremes();
        test_policies();
        test_overflow();
        test_backpressure();
        test_random();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+design
design/jss_pkg.sv
design/jss_cell.sv
design/jss_div.sv
design/job_schedule_simulator.sv
design/jss_port_check.sv
dv/tb_job_schedule_simulator.sv
